FILE: hdl/pbln_pkg.sv
// ----------------------------------------------------------------------------
// pbln_pkg
// Shared types, tables and defaults for the percentile band level normalizer.
// ----------------------------------------------------------------------------
package pbln_pkg;

  localparam int HIST_DEPTH_DEF = 128;
  localparam int BAND_COUNT_DEF = 16;

  localparam int MAG_W     = 24;
  localparam int BAND_W    = 4;
  localparam int LVL_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int TAB_W     = 17;
  localparam int WARMUP    = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FRAC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FRAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_HIGH  = 2'd3;

  localparam logic [LVL_W-1:0] LOW_FRAC_RST  = 9'd26;
  localparam logic [LVL_W-1:0] HIGH_FRAC_RST = 9'd230;
  localparam logic [LVL_W-1:0] LVL_LOW_RST   = 9'd0;
  localparam logic [LVL_W-1:0] LVL_HIGH_RST  = 9'd256;
  localparam logic [LVL_W-1:0] LVL_FULL      = 9'd256;

  localparam logic [TAB_W-1:0] FLOOR_TAB [16] = '{
    17'd2100, 17'd1650, 17'd1150, 17'd900, 17'd650, 17'd450, 17'd350, 17'd500,
    17'd350,  17'd360,  17'd430,  17'd320, 17'd180, 17'd280, 17'd180, 17'd240};
  localparam logic [TAB_W-1:0] CEIL_TAB [16] = '{
    17'd82000, 17'd69000, 17'd42000, 17'd17000, 17'd10000, 17'd9500, 17'd5700,
    17'd6500,  17'd6500,  17'd6000,  17'd2900,  17'd4900,  17'd950,  17'd800,
    17'd750,   17'd600};
  // 15% of (ceiling - floor), truncated
  localparam logic [TAB_W-1:0] MIN_SPAN_TAB [16] = '{
    17'd11985, 17'd10102, 17'd6127, 17'd2415, 17'd1402, 17'd1357, 17'd802,
    17'd900,   17'd922,   17'd846,  17'd370,  17'd687,  17'd115,  17'd78,
    17'd85,    17'd54};

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_WRITE = 10'b0000000010,
    ST_RANK  = 10'b0000000100,
    ST_BLEND = 10'b0000001000,
    ST_SPAN  = 10'b0000010000,
    ST_MUL   = 10'b0000100000,
    ST_LOAD  = 10'b0001000000,
    ST_DIV   = 10'b0010000000,
    ST_FIN   = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } pbln_state_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic rank_run;
    logic blend;
    logic span;
    logic mul;
    logic div_start;
    logic fin;
    logic load_out;
  } pbln_cmd_t;

  typedef struct packed {
    logic band_ok;
    logic rank_fin;
    logic div_done;
    logic out_busy;
  } pbln_st_t;

endpackage

FILE: hdl/percentile_band_level_normalizer.sv
// ----------------------------------------------------------------------------
// percentile_band_level_normalizer
// Per-band percentile tracking and linear mapping of magnitudes to bar levels.
// ----------------------------------------------------------------------------
// One word in carries a band index and a magnitude; one word out carries the
// same band and its level (0..256, 256 = full). Bands arrive 0..BAND_COUNT-1
// per window; the last band advances the history slot. Bands at or beyond
// BAND_COUNT are dropped without a result. The block handles one word at a
// time; the work per word grows with n, the number of filled history entries
// (up to HISTORY_DEPTH), set by the bit-per-pass rank select that reads the
// history memory once per entry per magnitude bit, plus a serial divider. A
// finished result waits in the output register while the next word is taken.
// Configuration writes take effect at once and are expected only while the
// block is idle.
module percentile_band_level_normalizer #(
  parameter int HISTORY_DEPTH = pbln_pkg::HIST_DEPTH_DEF,
  parameter int BAND_COUNT    = pbln_pkg::BAND_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,  // [23:0] magnitude
  input  logic [pbln_pkg::BAND_W-1:0]    in_tuser,  // [3:0] band_index
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // [8:0] level, [15:9] zero
  output logic [pbln_pkg::BAND_W-1:0]    out_tuser, // [3:0] out_band
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pbln_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbln_pkg::LVL_W-1:0]     cfg_data
);
  import pbln_pkg::*;

  pbln_cmd_t        cmd;
  pbln_st_t         st;
  logic [LVL_W-1:0] level;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  pbln_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pbln_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .BAND_COUNT    (BAND_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_band   (in_tuser),
    .in_mag    (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_band  (out_tuser),
    .out_level (level)
  );

  assign out_tdata = {7'd0, level};

endmodule

FILE: hdl/pbln_div.sv
// ----------------------------------------------------------------------------
// pbln_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbln_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? DEN_W'(shifted - {1'b0, den}) : DEN_W'(shifted);
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign quo  = quo_r;

endmodule

FILE: hdl/pbln_dp.sv
// ----------------------------------------------------------------------------
// pbln_dp
// Datapath: history memory, radix rank select, blend, span and level mapping.
// ----------------------------------------------------------------------------
module pbln_dp #(
  parameter int HISTORY_DEPTH = pbln_pkg::HIST_DEPTH_DEF,
  parameter int BAND_COUNT    = pbln_pkg::BAND_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pbln_pkg::pbln_cmd_t            cmd,
  output pbln_pkg::pbln_st_t             st,
  input  logic [pbln_pkg::BAND_W-1:0]    in_band,
  input  logic [pbln_pkg::MAG_W-1:0]     in_mag,
  input  logic                           cfg_we,
  input  logic [pbln_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pbln_pkg::LVL_W-1:0]     cfg_val,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pbln_pkg::BAND_W-1:0]    out_band,
  output logic [pbln_pkg::LVL_W-1:0]     out_level
);
  import pbln_pkg::*;

  localparam int HW    = $clog2(HISTORY_DEPTH);
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int DEPTH = BAND_COUNT * HISTORY_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NUM_W = 35;
  localparam int DEN_W = 25;

  // configuration
  logic [LVL_W-1:0] lo_frac_r, hi_frac_r, lvl_lo_r, lvl_hi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_frac_r <= LOW_FRAC_RST;
      hi_frac_r <= HIGH_FRAC_RST;
      lvl_lo_r  <= LVL_LOW_RST;
      lvl_hi_r  <= LVL_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LOW_FRAC:  lo_frac_r <= cfg_val;
        REG_HIGH_FRAC: hi_frac_r <= cfg_val;
        REG_LVL_LOW:   lvl_lo_r  <= cfg_val;
        REG_LVL_HIGH:  lvl_hi_r  <= cfg_val;
        default:       lo_frac_r <= lo_frac_r;
      endcase
    end
  end

  // item and window state
  logic [BAND_W-1:0] band_r;
  logic [MAG_W-1:0]  mag_r;
  logic [HW-1:0]     pos_r;
  logic [CW-1:0]     filled_r;
  logic [CW-1:0]     n_w;
  logic              last_band;

  assign n_w = (filled_r >= CW'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH) : filled_r + 1'b1;
  assign last_band = 32'(band_r) == BAND_COUNT - 1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      band_r <= in_band;
      mag_r  <= in_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      filled_r <= '0;
    end else if (cmd.fin && last_band) begin
      pos_r    <= (32'(pos_r) == HISTORY_DEPTH - 1) ? '0 : pos_r + 1'b1;
      if (filled_r < CW'(HISTORY_DEPTH)) filled_r <= filled_r + 1'b1;
    end
  end

  // history memory
  logic [MAG_W-1:0] mem [DEPTH];
  logic [MAG_W-1:0] rd_q;
  logic [AW-1:0]    base_addr;
  logic             rd_en;
  logic [CW-1:0]    idx_r, idx_nxt;

  assign base_addr = AW'(AW'(band_r) * AW'(HISTORY_DEPTH));
  assign rd_en     = cmd.rank_run && (idx_r < n_w);

  always_ff @(posedge clk) begin
    if (cmd.write) mem[base_addr + AW'(pos_r)] <= mag_r;
    if (rd_en) rd_q <= mem[base_addr + AW'(idx_r)];
  end

  // target ranks
  logic [CW+9:0] kl_prod, kh_prod;
  logic [CW+1:0] kl_raw, kh_raw;
  logic [CW-1:0] n_m1, kl_init, kh_init;

  assign n_m1    = n_w - 1'b1;
  assign kl_prod = (CW+10)'(lo_frac_r) * (CW+10)'(n_m1) + (CW+10)'(128);
  assign kh_prod = (CW+10)'(hi_frac_r) * (CW+10)'(n_m1) + (CW+10)'(128);
  assign kl_raw  = kl_prod[CW+9:8];
  assign kh_raw  = kh_prod[CW+9:8];
  assign kl_init = (kl_raw > (CW+2)'(n_m1)) ? n_m1 : CW'(kl_raw);
  assign kh_init = (kh_raw > (CW+2)'(n_m1)) ? n_m1 : CW'(kh_raw);

  // radix select, one bit per pass over the n entries, both anchors at once
  logic [4:0]       bit_r, bit_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    cnt_lo_r, cnt_lo_nxt, cnt_hi_r, cnt_hi_nxt;
  logic [CW-1:0]    k_lo_r, k_lo_nxt, k_hi_r, k_hi_nxt;
  logic [MAG_W-1:0] pre_lo_r, pre_lo_nxt, pre_hi_r, pre_hi_nxt;
  logic [MAG_W-1:0] mask;
  logic             hit_lo, hit_hi, pass_end;
  logic [CW-1:0]    cnt_lo_fin, cnt_hi_fin;

  assign mask       = {MAG_W{1'b1}} << (6'(bit_r) + 6'd1);
  assign hit_lo     = ((rd_q & mask) == (pre_lo_r & mask)) && !rd_q[bit_r];
  assign hit_hi     = ((rd_q & mask) == (pre_hi_r & mask)) && !rd_q[bit_r];
  assign cnt_lo_fin = cnt_lo_r + CW'(hit_lo);
  assign cnt_hi_fin = cnt_hi_r + CW'(hit_hi);
  assign pass_end   = pend_r && (idx_r == n_w);

  always_comb begin
    idx_nxt    = idx_r;
    bit_nxt    = bit_r;
    pend_nxt   = pend_r;
    cnt_lo_nxt = cnt_lo_r;
    cnt_hi_nxt = cnt_hi_r;
    k_lo_nxt   = k_lo_r;
    k_hi_nxt   = k_hi_r;
    pre_lo_nxt = pre_lo_r;
    pre_hi_nxt = pre_hi_r;
    if (cmd.write) begin
      idx_nxt    = '0;
      bit_nxt    = 5'(MAG_W - 1);
      pend_nxt   = 1'b0;
      cnt_lo_nxt = '0;
      cnt_hi_nxt = '0;
      k_lo_nxt   = kl_init;
      k_hi_nxt   = kh_init;
      pre_lo_nxt = '0;
      pre_hi_nxt = '0;
    end else if (cmd.rank_run) begin
      pend_nxt = rd_en;
      if (rd_en) idx_nxt = idx_r + 1'b1;
      if (pend_r) begin
        cnt_lo_nxt = cnt_lo_fin;
        cnt_hi_nxt = cnt_hi_fin;
      end
      if (pass_end) begin
        // no more entries below than the target rank: this bit is one
        if (k_lo_r >= cnt_lo_fin) begin
          pre_lo_nxt[bit_r] = 1'b1;
          k_lo_nxt          = k_lo_r - cnt_lo_fin;
        end
        if (k_hi_r >= cnt_hi_fin) begin
          pre_hi_nxt[bit_r] = 1'b1;
          k_hi_nxt          = k_hi_r - cnt_hi_fin;
        end
        cnt_lo_nxt = '0;
        cnt_hi_nxt = '0;
        idx_nxt    = '0;
        bit_nxt    = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      idx_r  <= '0;
      bit_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
      bit_r  <= bit_nxt;
    end
    cnt_lo_r <= cnt_lo_nxt;
    cnt_hi_r <= cnt_hi_nxt;
    k_lo_r   <= k_lo_nxt;
    k_hi_r   <= k_hi_nxt;
    pre_lo_r <= pre_lo_nxt;
    pre_hi_r <= pre_hi_nxt;
  end

  // blend with the band tables during warm-up
  logic [TAB_W-1:0] fl, ce, ms;
  logic             warm;
  logic [6:0]       n6, w6;
  logic [23:0]      pa_lo_r, pa_hi_r;
  logic [30:0]      pb_lo_r, pb_hi_r;

  assign fl   = FLOOR_TAB[band_r];
  assign ce   = CEIL_TAB[band_r];
  assign ms   = MIN_SPAN_TAB[band_r];
  assign warm = n_w < CW'(WARMUP);
  assign n6   = 7'(n_w);
  assign w6   = 7'(WARMUP) - n6;

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      pa_lo_r <= 24'(fl) * 24'(w6);
      pa_hi_r <= 24'(ce) * 24'(w6);
      pb_lo_r <= 31'(pre_lo_r) * 31'(n6);
      pb_hi_r <= 31'(pre_hi_r) * 31'(n6);
    end
  end

  logic [31:0]      sum_lo, sum_hi;
  logic [MAG_W-1:0] low_b, high_b, low_c;
  logic [MAG_W:0]   high_s;
  logic [MAG_W-1:0] low_r;
  logic [MAG_W:0]   high_r;

  assign sum_lo = 32'(pa_lo_r) + 32'(pb_lo_r);
  assign sum_hi = 32'(pa_hi_r) + 32'(pb_hi_r);
  assign low_b  = warm ? MAG_W'(sum_lo >> 6) : pre_lo_r;
  assign high_b = warm ? MAG_W'(sum_hi >> 6) : pre_hi_r;
  assign low_c  = (low_b < MAG_W'(fl)) ? MAG_W'(fl) : low_b;
  assign high_s = (MAG_W+1)'(low_c) + (MAG_W+1)'(ms);

  always_ff @(posedge clk) begin
    if (cmd.span) begin
      low_r  <= low_c;
      high_r <= ((MAG_W+1)'(high_b) < high_s) ? high_s : (MAG_W+1)'(high_b);
    end
  end

  // slope numerator, sign split off for the unsigned divider
  logic signed [25:0] diff;
  logic signed [9:0]  dlt;
  logic signed [35:0] prod;
  logic               neg_r;
  logic [NUM_W-1:0]   num_r, quo;
  logic [DEN_W-1:0]   den_r;
  logic               div_done;

  assign diff = $signed({2'b0, mag_r}) - $signed({2'b0, low_r});
  assign dlt  = $signed({1'b0, lvl_hi_r}) - $signed({1'b0, lvl_lo_r});
  assign prod = 36'(diff) * 36'(dlt);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg_r <= prod < 0;
      num_r <= (prod < 0) ? NUM_W'(-prod) : NUM_W'(prod);
      den_r <= DEN_W'(high_r - (MAG_W+1)'(low_r));
    end
  end

  pbln_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  // final level, clamped
  logic signed [36:0] lvl_s;
  logic [LVL_W-1:0]   level_r;

  assign lvl_s = neg_r ? $signed({28'd0, lvl_lo_r}) - $signed({2'b0, quo})
                       : $signed({28'd0, lvl_lo_r}) + $signed({2'b0, quo});

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (MAG_W'(fl) >= mag_r || lvl_s < 0) level_r <= '0;
      else if (lvl_s > 37'sd256) level_r <= LVL_FULL;
      else level_r <= LVL_W'(lvl_s);
    end
  end

  // output register
  logic             out_valid_r;
  logic [BAND_W-1:0] out_band_r;
  logic [LVL_W-1:0] out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
    if (cmd.load_out) begin
      out_band_r  <= band_r;
      out_level_r <= level_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_band    = out_band_r;
  assign out_level   = out_level_r;
  assign st.band_ok  = 32'(band_r) < BAND_COUNT;
  assign st.rank_fin = pass_end && (bit_r == 5'd0);
  assign st.div_done = div_done;
  assign st.out_busy = out_valid_r && !out_ready;

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CW'(HISTORY_DEPTH))
    else $error("window count beyond history depth");
  a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rank_run |-> (k_lo_r < n_w) && (k_hi_r < n_w))
    else $error("target rank outside the filled history");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rank_run |-> idx_r <= n_w)
    else $error("history scan ran past the filled entries");

endmodule

FILE: hdl/pbln_ctrl.sv
// ----------------------------------------------------------------------------
// pbln_ctrl
// Controller: sequences capture, rank select, arithmetic and result hand-off.
// ----------------------------------------------------------------------------
module pbln_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbln_pkg::pbln_st_t  st,
  output pbln_pkg::pbln_cmd_t cmd
);
  import pbln_pkg::*;

  pbln_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // drop bands at or beyond the configured count
        cmd.write = st.band_ok;
        state_nxt = st.band_ok ? ST_RANK : ST_IDLE;
      end
      ST_RANK: begin
        cmd.rank_run = 1'b1;
        if (st.rank_fin) state_nxt = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.blend = 1'b1;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.span  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (st.div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.load_out = !st.out_busy;
        if (!st.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  assign in_ready = state_r == ST_IDLE;

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the percentile band level normalizer: sends whole
// windows of band magnitudes under random idling and checks every level word.
// ----------------------------------------------------------------------------
module tb;
  import pbln_pkg::*;

  localparam int N_BANDS   = 16;
  localparam int N_HIST    = 128;
  localparam int N_WINDOWS = 73;
  localparam int PHASE_LEN = 9;
  localparam int QUIET_AT  = 1050;  // words sent before idling stops
  localparam int HOLD_AT   = 400;   // words sent before the long output hold
  localparam int HOLD_LEN  = 8000;

  typedef struct {
    logic [BAND_W-1:0] band;
    logic [LVL_W-1:0]  level;
  } level_word_t;

  // Predicts the level of each accepted word and keeps the expected words.
  class level_scoreboard;
    logic [MAG_W-1:0] hist [N_BANDS][N_HIST];
    int unsigned      slot;
    int unsigned      windows;
    int unsigned      frac_lo, frac_hi, lvl_lo, lvl_hi;
    level_word_t      expected [$];

    function void reset_state();
      slot = 0;
      windows = 0;
      frac_lo = LOW_FRAC_RST;
      frac_hi = HIGH_FRAC_RST;
      lvl_lo  = LVL_LOW_RST;
      lvl_hi  = LVL_HIGH_RST;
      expected.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] val);
      case (idx)
        REG_LOW_FRAC:  frac_lo = val;
        REG_HIGH_FRAC: frac_hi = val;
        REG_LVL_LOW:   lvl_lo  = val;
        REG_LVL_HIGH:  lvl_hi  = val;
        default: ;
      endcase
    endfunction

    // k-th smallest of the first n history slots of band b
    function int unsigned percentile(int b, int unsigned n, int unsigned frac);
      int unsigned k, below, not_above;
      k = (frac * (n - 1) + 128) >> 8;
      if (k > n - 1) k = n - 1;
      for (int i = 0; i < n; i++) begin
        below = 0;
        not_above = 0;
        for (int j = 0; j < n; j++) begin
          if (hist[b][j] < hist[b][i]) below++;
          if (hist[b][j] <= hist[b][i]) not_above++;
        end
        if (below <= k && k < not_above) return hist[b][i];
      end
      return hist[b][0];
    endfunction

    function void note_word(logic [BAND_W-1:0] b, logic [MAG_W-1:0] m);
      int unsigned n;
      longint fl, ce, lo, hi, span, den, dl, lvl;
      level_word_t w;
      hist[b][slot] = m;
      n = windows + 1;
      if (n > N_HIST) n = N_HIST;
      fl = FLOOR_TAB[b];
      ce = CEIL_TAB[b];
      lo = percentile(b, n, frac_lo);
      hi = percentile(b, n, frac_hi);
      if (n < WARMUP) begin
        lo = (fl * (WARMUP - n) + lo * n) / WARMUP;
        hi = (ce * (WARMUP - n) + hi * n) / WARMUP;
      end
      if (lo < fl) lo = fl;
      span = (ce - fl) * 15 / 100;
      if (hi - lo < span) hi = lo + span;
      if (m <= fl) begin
        lvl = 0;
      end else begin
        den = hi - lo;
        if (den <= 0) den = 1;
        dl  = longint'(lvl_hi) - longint'(lvl_lo);
        lvl = longint'(lvl_lo) + ((longint'(m) - lo) * dl) / den;
        if (lvl < 0) lvl = 0;
        if (lvl > 256) lvl = 256;
      end
      if (b == N_BANDS - 1) begin
        slot = (slot + 1) % N_HIST;
        if (windows < N_HIST) windows++;
      end
      w.band  = b;
      w.level = lvl[LVL_W-1:0];
      expected.push_back(w);
    endfunction

    // returns an empty string on a match, else a description
    function string check_word(logic [BAND_W-1:0] b, logic [LVL_W-1:0] l);
      level_word_t w;
      if (expected.size() == 0) return $sformatf("unexpected word band %0d level %0d", b, l);
      w = expected.pop_front();
      if (w.band !== b || w.level !== l)
        return $sformatf("band %0d level %0d, expected band %0d level %0d",
                         b, l, w.band, w.level);
      return "";
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;
  logic [BAND_W-1:0]    in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;
  logic [BAND_W-1:0]    out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LVL_W-1:0]     cfg_data;

  level_scoreboard sb;
  int  fail_count;
  int  sent_count;
  int  got_count;
  int  cfg_count;
  bit  quiet;
  bit  hold_done;

  percentile_band_level_normalizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [23:0] magnitude
    .in_tuser   (in_tuser),   // [3:0] band_index
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [8:0] level, [15:9] zero
    .out_tuser  (out_tuser),  // [3:0] out_band
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #(64'd400_000_000);
    $display("[percentile_band_level_normalizer] ERROR");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // Offer one word; idle for a random burst first unless in the quiet tail.
  task automatic send_word(input logic [BAND_W-1:0] b, input logic [23:0] m);
    int gap;
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(10, 1) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= b;
    in_tdata  <= m;
    do @(posedge clk); while (!in_tready);
    sb.note_word(b, m);
    sent_count++;
    if (sent_count >= QUIET_AT) quiet = 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_count++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all expected words, then give the block a little slack.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [LVL_W-1:0] pick_reg();
    case ($urandom_range(3))
      0: return 9'd0;
      1: return LVL_FULL;
      default: return LVL_W'($urandom_range(256));
    endcase
  endfunction

  // Random magnitude, mostly near the band's floor-to-ceiling range.
  function automatic logic [23:0] pick_mag(int b);
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom());
      3: return 24'(FLOOR_TAB[b] + $urandom_range(1, 0));
      default: return 24'($urandom_range(CEIL_TAB[b] * 2));
    endcase
  endfunction

  // Receiver: random ready bursts, one long hold mid-run, steady in the tail.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      int len;
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else begin
        len = $urandom_range(10, 1);
        out_tready <= ($urandom_range(2) != 0);
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      msg = sb.check_word(out_tuser, out_tdata[LVL_W-1:0]);
      if (msg != "") report(msg);
      if (out_tdata[15:LVL_W] !== '0) report("nonzero padding in out_tdata");
      got_count++;
    end
  end

  initial begin
    int order [N_BANDS-1];
    logic [23:0] m;
    sb = new();
    sb.reset_state();
    fail_count = 0;
    sent_count = 0;
    got_count  = 0;
    cfg_count  = 0;
    quiet      = 1'b0;
    hold_done  = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_LOW_FRAC;
    cfg_data   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed window at reset defaults: magnitude extremes and floor edges.
    for (int b = 0; b < N_BANDS; b++) begin
      case (b % 4)
        0: m = 24'd0;
        1: m = 24'hFFFFFF;
        2: m = 24'(FLOOR_TAB[b]);
        default: m = 24'(FLOOR_TAB[b] + 1);
      endcase
      send_word(BAND_W'(b), m);
    end
    wait_idle();

    // Remaining windows, in phases with new register settings between them.
    for (int w = 1; w < N_WINDOWS; w++) begin
      if ((w - 1) % PHASE_LEN == 0) begin
        wait_idle();
        case ((w - 1) / PHASE_LEN)
          0: begin
            write_reg(REG_LOW_FRAC, 9'd0);   write_reg(REG_HIGH_FRAC, LVL_FULL);
            write_reg(REG_LVL_LOW, 9'd0);    write_reg(REG_LVL_HIGH, LVL_FULL);
          end
          1: begin  // inverted mapping and inverted ranks
            write_reg(REG_LOW_FRAC, LVL_FULL); write_reg(REG_HIGH_FRAC, 9'd0);
            write_reg(REG_LVL_LOW, LVL_FULL);  write_reg(REG_LVL_HIGH, 9'd0);
          end
          2: begin  // back to defaults
            write_reg(REG_LOW_FRAC, LOW_FRAC_RST); write_reg(REG_HIGH_FRAC, HIGH_FRAC_RST);
            write_reg(REG_LVL_LOW, LVL_LOW_RST);   write_reg(REG_LVL_HIGH, LVL_HIGH_RST);
          end
          default: begin
            write_reg(REG_LOW_FRAC, pick_reg()); write_reg(REG_HIGH_FRAC, pick_reg());
            write_reg(REG_LVL_LOW, pick_reg());  write_reg(REG_LVL_HIGH, pick_reg());
          end
        endcase
      end
      // shuffle bands 0..14 on some windows, repeat one now and then, close with the last band
      for (int i = 0; i < N_BANDS - 1; i++) order[i] = i;
      if ($urandom_range(1)) order.shuffle();
      foreach (order[i]) send_word(BAND_W'(order[i]), pick_mag(order[i]));
      if ($urandom_range(4) == 0) begin
        int rb;
        rb = $urandom_range(N_BANDS - 2);
        send_word(BAND_W'(rb), pick_mag(rb));
      end
      send_word(BAND_W'(N_BANDS - 1), pick_mag(N_BANDS - 1));
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("covered %0d words over %0d windows, %0d register writes, %0d levels checked",
             sent_count, N_WINDOWS, cfg_count, got_count);
    $display("warm-up blend through steady percentiles, shuffled bands, long output hold");
    if (fail_count == 0 && sb.expected.size() == 0) begin
      $display("[percentile_band_level_normalizer] OK");
    end else begin
      if (sb.expected.size() != 0) $display("%0d levels never arrived", sb.expected.size());
      $display("[percentile_band_level_normalizer] ERROR");
    end
    $finish;
  end

endmodule
